### sv/ilhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilhs_pkg
// Shared constants, codes and quantile fractions of the insert length
// histogram statistics block.
// ----------------------------------------------------------------------------
package ilhs_pkg;

  localparam int LENGTH_BINS_DEF = 2048;
  localparam int MODEL_COUNT_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int OP_W       = 2;
  localparam int MODEL_W    = 3;
  localparam int LEN_W      = 16;
  localparam int STAT_W     = 16;
  localparam int MODEL_OUT_W = 4;
  localparam int INTERVAL_W = 16;
  localparam int SAMPLE_W   = 32;
  localparam int FRAC_W     = 32;
  localparam int QUANT_N    = 5;
  localparam int QIDX_W     = 3;

  localparam logic [MODEL_OUT_W-1:0] INVALID_MODEL  = 4'd8;
  localparam logic [INTERVAL_W-1:0]  INTERVAL_RESET = 16'd1000;

  // quantile slots
  localparam logic [QIDX_W-1:0] Q_LO3 = 3'd0;
  localparam logic [QIDX_W-1:0] Q_LO1 = 3'd1;
  localparam logic [QIDX_W-1:0] Q_MED = 3'd2;
  localparam logic [QIDX_W-1:0] Q_HI1 = 3'd3;
  localparam logic [QIDX_W-1:0] Q_HI3 = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FINAL  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // 0.32 fixed-point quantile fractions
  function automatic logic [FRAC_W-1:0] quant_frac(input logic [QIDX_W-1:0] k);
    logic [FRAC_W-1:0] f;
    case (k)
      Q_LO3:   f = 32'd5797768;
      Q_LO1:   f = 32'd681419127;
      Q_MED:   f = 32'd2147483648;
      Q_HI1:   f = 32'd3613548169;
      Q_HI3:   f = 32'd4289169528;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

### sv/ilhs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilhs_item_if / ilhs_result_if
// Valid/ready channels carrying input samples and statistics results.
// ----------------------------------------------------------------------------
interface ilhs_item_if;
  logic                          valid;
  logic                          ready;
  logic [ilhs_pkg::OP_W-1:0]     operation;
  logic [ilhs_pkg::MODEL_W-1:0]  model;
  logic [ilhs_pkg::LEN_W-1:0]    length;

  modport source(output valid, operation, model, length, input ready);
  modport sink(input valid, operation, model, length, output ready);
endinterface

interface ilhs_result_if;
  logic                              valid;
  logic                              ready;
  logic                              stable;
  logic                              updated;
  logic [ilhs_pkg::STAT_W-1:0]       min_length;
  logic [ilhs_pkg::STAT_W-1:0]       median_length;
  logic [ilhs_pkg::STAT_W-1:0]       max_length;
  logic [ilhs_pkg::STAT_W-1:0]       low_spread;
  logic [ilhs_pkg::STAT_W-1:0]       high_spread;
  logic [ilhs_pkg::MODEL_OUT_W-1:0]  best_model;
  logic [ilhs_pkg::MODEL_OUT_W-1:0]  second_model;

  modport source(output valid, stable, updated, min_length, median_length, max_length,
                 low_spread, high_spread, best_model, second_model, input ready);
  modport sink(input valid, stable, updated, min_length, median_length, max_length,
               low_spread, high_spread, best_model, second_model, output ready);
endinterface

### sv/ilhs_bin_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilhs_bin_mem
// Bin count memory, one row per length bin holding all model lanes.
// ----------------------------------------------------------------------------
module ilhs_bin_mem #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/ilhs_thresh.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilhs_thresh
// Shift-add multiplier computing floor(total * fraction / 2^32) for all
// five quantile fractions, one fraction bit per cycle.
// ----------------------------------------------------------------------------
module ilhs_thresh #(
  parameter int TW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [TW-1:0] total,
  output logic          done,
  output logic [TW-1:0] thr [ilhs_pkg::QUANT_N]
);

  localparam int AccW = TW + ilhs_pkg::FRAC_W;
  localparam logic [4:0] LAST_BIT = 5'(ilhs_pkg::FRAC_W - 1);
  localparam logic [ilhs_pkg::QIDX_W-1:0] LAST_Q = ilhs_pkg::QIDX_W'(ilhs_pkg::QUANT_N - 1);

  logic                          busy;
  logic [ilhs_pkg::QIDX_W-1:0]   k;
  logic [4:0]                    bitc;
  logic [AccW-1:0]               acc;
  logic [AccW-1:0]               acc_next;
  logic [TW-1:0]                 tot_r;
  logic [ilhs_pkg::FRAC_W-1:0]   frac;

  always_comb begin
    frac = ilhs_pkg::quant_frac(k);
    acc_next = {acc[AccW-2:0], 1'b0};
    if (frac[LAST_BIT - bitc]) begin
      acc_next = acc_next + AccW'(tot_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      k    <= '0;
      bitc <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        k     <= '0;
        bitc  <= '0;
        acc   <= '0;
        tot_r <= total;
      end else if (busy) begin
        if (bitc == LAST_BIT) begin
          thr[k] <= acc_next[ilhs_pkg::FRAC_W +: TW];
          acc    <= '0;
          bitc   <= '0;
          if (k == LAST_Q) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            k <= k + 1'b1;
          end
        end else begin
          acc  <= acc_next;
          bitc <= bitc + 1'b1;
        end
      end
    end
  end

endmodule

### sv/ilhs_residue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ilhs_residue
// Restoring remainder unit: sample count modulo update interval, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module ilhs_residue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [ilhs_pkg::SAMPLE_W-1:0]   dividend,
  input  logic [ilhs_pkg::INTERVAL_W-1:0] divisor,
  output logic                            done,
  output logic [ilhs_pkg::INTERVAL_W-1:0] rem
);

  localparam logic [4:0] LAST_BIT = 5'(ilhs_pkg::SAMPLE_W - 1);

  logic                            busy;
  logic [4:0]                      bitc;
  logic [ilhs_pkg::SAMPLE_W-1:0]   dvd;
  logic [ilhs_pkg::INTERVAL_W-1:0] dvs;
  logic [ilhs_pkg::INTERVAL_W:0]   trial;

  always_comb begin
    trial = {rem, dvd[LAST_BIT - bitc]};
    if (trial >= {1'b0, dvs}) begin
      trial = trial - {1'b0, dvs};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bitc <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        bitc <= '0;
        rem  <= '0;
        dvd  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= trial[ilhs_pkg::INTERVAL_W-1:0];
        if (bitc == LAST_BIT) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bitc <= bitc + 1'b1;
        end
      end
    end
  end

endmodule

### sv/insert_length_histogram_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insert_length_histogram_stats
// Per-model insert length histograms with periodic quantile statistics.
// ----------------------------------------------------------------------------
// Items are handled one at a time and every item gives one result. An append
// reads the bin memory row of its length and writes it back. A recomputation
// (finalize, or an append that completes an update interval) runs the model
// scan, the bit-serial threshold multiplier and the walk over every bin memory
// row. Clear sweeps the bin memory to zero; after reset the block also sweeps
// it to zero before it takes items. A write of update_interval holds off the
// next item while a remainder pass runs, a pass that is skipped when the new
// interval is zero. Results wait in an output register.
module insert_length_histogram_stats #(
  parameter int LENGTH_BINS = ilhs_pkg::LENGTH_BINS_DEF,
  parameter int MODEL_COUNT = ilhs_pkg::MODEL_COUNT_DEF,
  parameter int COUNT_WIDTH = ilhs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [ilhs_pkg::INTERVAL_W-1:0] cfg_wr_data,
  ilhs_item_if.sink                       item,
  ilhs_result_if.source                   result
);

  localparam int AW  = $clog2(LENGTH_BINS);
  localparam int MIW = $clog2(MODEL_COUNT);
  localparam int TW  = COUNT_WIDTH + 1;
  localparam int PW  = COUNT_WIDTH + 2;
  localparam int RW  = MODEL_COUNT * COUNT_WIDTH;
  localparam int SW  = ilhs_pkg::STAT_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [AW-1:0]          LAST_BIN   = AW'(LENGTH_BINS - 1);
  localparam logic [MIW-1:0]         LAST_MODEL = MIW'(MODEL_COUNT - 1);

  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_MOD  = 9'b000000100,
    S_APP  = 9'b000001000,
    S_SEL  = 9'b000010000,
    S_THR  = 9'b000100000,
    S_WALK = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   clr_i;
  logic                            clr_report;
  logic [MIW-1:0]                  model_r;
  logic [AW-1:0]                   len_r;
  logic [ilhs_pkg::INTERVAL_W-1:0] interval;
  logic [ilhs_pkg::SAMPLE_W-1:0]   counted;
  logic [ilhs_pkg::INTERVAL_W-1:0] resid;
  logic                            stale;
  logic [COUNT_WIDTH-1:0]          totals [MODEL_COUNT];
  logic [MIW-1:0]                  b0;
  logic [MIW-1:0]                  b1;
  logic [COUNT_WIDTH-1:0]          t0;
  logic [COUNT_WIDTH-1:0]          t1;
  logic [MIW-1:0]                  m_cnt;
  logic [TW-1:0]                   total_r;
  logic [AW-1:0]                   walk_i;
  logic                            walk_issued;
  logic                            pv;
  logic [AW-1:0]                   idx_d;
  logic [PW-1:0]                   pos;
  logic [SW-1:0]                   q [ilhs_pkg::QUANT_N];
  logic [SW-1:0]                   min_q;
  logic [SW-1:0]                   med_q;
  logic [SW-1:0]                   max_q;
  logic [SW-1:0]                   lspr;
  logic [SW-1:0]                   hspr;
  logic                            chosen_ok;
  logic                            stable_r;
  logic                            upd_r;
  logic                            thr_start;
  logic                            mod_start;

  logic                            item_acc;
  logic                            sample_ok;
  logic                            slot_free;
  logic                            res_load;
  logic                            res_upd;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [RW-1:0]                   mem_wdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;
  logic [RW-1:0]                   mem_rdata;
  logic [COUNT_WIDTH-1:0]          lanes [MODEL_COUNT];
  logic [RW-1:0]                   row_mod;
  logic [ilhs_pkg::SAMPLE_W-1:0]   counted_inc;
  logic [ilhs_pkg::INTERVAL_W:0]   resid_inc;
  logic [ilhs_pkg::INTERVAL_W-1:0] resid_next;
  logic                            trig;
  logic [COUNT_WIDTH-1:0]          tm;
  logic [TW-1:0]                   pair_total;
  logic [PW-1:0]                   pos_sum;
  logic [PW-1:0]                   pos_next;
  logic [SW-1:0]                   nl;
  logic [SW-1:0]                   nh;
  logic                            thr_done;
  logic [TW-1:0]                   thr [ilhs_pkg::QUANT_N];
  logic                            mod_done;
  logic [ilhs_pkg::INTERVAL_W-1:0] mod_rem;

  assign item.ready = (state == S_IDLE) && !stale;
  assign item_acc   = item.valid && item.ready;
  assign sample_ok  = ({1'b0, item.length} < (ilhs_pkg::LEN_W + 1)'(LENGTH_BINS)) &&
                      ({1'b0, item.model} < (ilhs_pkg::MODEL_W + 1)'(MODEL_COUNT));
  assign slot_free  = !result.valid || result.ready;

  // row lanes and the saturating increment of the appended lane
  always_comb begin
    for (int j = 0; j < MODEL_COUNT; j++) begin
      lanes[j] = mem_rdata[j*COUNT_WIDTH +: COUNT_WIDTH];
    end
    row_mod = mem_rdata;
    for (int j = 0; j < MODEL_COUNT; j++) begin
      if (MIW'(j) == model_r && lanes[j] != COUNT_MAX) begin
        row_mod[j*COUNT_WIDTH +: COUNT_WIDTH] = lanes[j] + 1'b1;
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = len_r;
    mem_wdata = row_mod;
    mem_re    = 1'b0;
    mem_raddr = walk_i;
    if (state == S_CLR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_i;
      mem_wdata = '0;
    end else if (state == S_APP) begin
      mem_we = 1'b1;
    end else if (state == S_IDLE) begin
      mem_re    = item_acc && (item.operation == ilhs_pkg::OP_APPEND) && sample_ok;
      mem_raddr = item.length[AW-1:0];
    end else if (state == S_WALK) begin
      mem_re = !walk_issued;
    end
  end

  // interval residue tracking; a wrap of the sample count restarts it at zero
  always_comb begin
    counted_inc = counted + 1'b1;
    resid_inc   = {1'b0, resid} + 1'b1;
    if (counted_inc == '0 || resid_inc == {1'b0, interval}) begin
      resid_next = '0;
    end else begin
      resid_next = resid_inc[ilhs_pkg::INTERVAL_W-1:0];
    end
    trig = (interval != '0) && (resid_next == '0);
  end

  always_comb begin
    tm         = totals[m_cnt];
    pair_total = TW'(t0) + TW'(t1);
    pos_sum    = pos + PW'(lanes[b0]) + PW'(lanes[b1]);
    if (pos_sum > PW'(total_r)) begin
      pos_next = PW'(total_r) + 1'b1;
    end else begin
      pos_next = pos_sum;
    end
    nl = q[ilhs_pkg::Q_MED] - q[ilhs_pkg::Q_LO1];
    nh = q[ilhs_pkg::Q_HI1] - q[ilhs_pkg::Q_MED];
  end

  always_comb begin
    res_load = 1'b0;
    res_upd  = upd_r;
    if (state == S_APP && !trig && slot_free) begin
      res_load = 1'b1;
      res_upd  = 1'b0;
    end else if (state == S_DONE && slot_free) begin
      res_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      clr_i      <= '0;
      clr_report <= 1'b0;
      interval   <= ilhs_pkg::INTERVAL_RESET;
      counted    <= '0;
      resid      <= '0;
      stale      <= 1'b0;
      for (int j = 0; j < MODEL_COUNT; j++) begin
        totals[j] <= '0;
      end
      min_q      <= '1;
      med_q      <= '1;
      max_q      <= '1;
      lspr       <= '1;
      hspr       <= '1;
      chosen_ok  <= 1'b0;
      stable_r   <= 1'b0;
      upd_r      <= 1'b0;
      thr_start  <= 1'b0;
      mod_start  <= 1'b0;
      pv         <= 1'b0;
    end else begin
      thr_start <= 1'b0;
      mod_start <= 1'b0;
      pv        <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_i <= clr_i + 1'b1;
          if (clr_i == LAST_BIN) begin
            clr_i <= '0;
            upd_r <= 1'b0;
            state <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (stale) begin
            if (interval == '0) begin
              stale <= 1'b0;
            end else begin
              mod_start <= 1'b1;
              state     <= S_MOD;
            end
          end else if (item_acc) begin
            model_r <= item.model[MIW-1:0];
            len_r   <= item.length[AW-1:0];
            upd_r   <= 1'b0;
            case (ilhs_pkg::op_t'(item.operation))
              ilhs_pkg::OP_APPEND: begin
                state <= sample_ok ? S_APP : S_DONE;
              end
              ilhs_pkg::OP_FINAL: begin
                m_cnt <= '0;
                state <= S_SEL;
              end
              ilhs_pkg::OP_CLEAR: begin
                for (int j = 0; j < MODEL_COUNT; j++) begin
                  totals[j] <= '0;
                end
                counted    <= '0;
                resid      <= '0;
                min_q      <= '1;
                med_q      <= '1;
                max_q      <= '1;
                lspr       <= '1;
                hspr       <= '1;
                chosen_ok  <= 1'b0;
                stable_r   <= 1'b0;
                clr_report <= 1'b1;
                state      <= S_CLR;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MOD: begin
          if (mod_done) begin
            resid <= mod_rem;
            stale <= 1'b0;
            state <= S_IDLE;
          end
        end
        S_APP: begin
          if (totals[model_r] != COUNT_MAX) begin
            totals[model_r] <= totals[model_r] + 1'b1;
          end
          counted <= counted_inc;
          resid   <= resid_next;
          if (trig) begin
            m_cnt <= '0;
            state <= S_SEL;
          end else if (slot_free) begin
            state <= S_IDLE;
          end else begin
            state <= S_DONE;
          end
        end
        S_SEL: begin
          // ties keep the earlier model
          if (m_cnt == '0) begin
            b0 <= '0;
            t0 <= tm;
          end else if (m_cnt == MIW'(1)) begin
            if (tm <= t0) begin
              b1 <= m_cnt;
              t1 <= tm;
            end else begin
              b1 <= b0;
              t1 <= t0;
              b0 <= m_cnt;
              t0 <= tm;
            end
          end else if (tm > t0) begin
            b1 <= b0;
            t1 <= t0;
            b0 <= m_cnt;
            t0 <= tm;
          end else if (tm > t1) begin
            b1 <= m_cnt;
            t1 <= tm;
          end
          if (m_cnt == LAST_MODEL) begin
            thr_start <= 1'b1;
            state     <= S_THR;
          end else begin
            m_cnt <= m_cnt + 1'b1;
          end
        end
        S_THR: begin
          total_r <= pair_total;
          if (thr_done) begin
            walk_i      <= '0;
            walk_issued <= 1'b0;
            pos         <= '0;
            state       <= S_WALK;
          end
        end
        S_WALK: begin
          if (!walk_issued) begin
            if (walk_i == LAST_BIN) begin
              walk_issued <= 1'b1;
            end else begin
              walk_i <= walk_i + 1'b1;
            end
          end
          pv    <= !walk_issued;
          idx_d <= walk_i;
          if (pv) begin
            for (int k = 0; k < ilhs_pkg::QUANT_N; k++) begin
              if (pos <= PW'(thr[k])) begin
                q[k] <= SW'(idx_d);
              end
            end
            pos <= pos_next;
            if (idx_d == LAST_BIN) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (q[ilhs_pkg::Q_LO3] == min_q && q[ilhs_pkg::Q_MED] == med_q &&
              q[ilhs_pkg::Q_HI3] == max_q && nl == lspr && nh == hspr) begin
            stable_r <= 1'b1;
          end
          min_q     <= q[ilhs_pkg::Q_LO3];
          med_q     <= q[ilhs_pkg::Q_MED];
          max_q     <= q[ilhs_pkg::Q_HI3];
          lspr      <= nl;
          hspr      <= nh;
          chosen_ok <= 1'b1;
          upd_r     <= 1'b1;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a new interval needs a fresh residue
      if (cfg_wr_en) begin
        interval <= cfg_wr_data;
        stale    <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.stable        <= stable_r;
      result.updated       <= res_upd;
      result.min_length    <= min_q;
      result.median_length <= med_q;
      result.max_length    <= max_q;
      result.low_spread    <= lspr;
      result.high_spread   <= hspr;
      result.best_model    <= chosen_ok ? ilhs_pkg::MODEL_OUT_W'(b0) : ilhs_pkg::INVALID_MODEL;
      result.second_model  <= chosen_ok ? ilhs_pkg::MODEL_OUT_W'(b1) : ilhs_pkg::INVALID_MODEL;
    end
  end

  ilhs_bin_mem #(
    .DEPTH(LENGTH_BINS),
    .WIDTH(RW)
  ) u_bin_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ilhs_thresh #(
    .TW(TW)
  ) u_thresh (
    .clk   (clk),
    .rst   (rst),
    .start (thr_start),
    .total (pair_total),
    .done  (thr_done),
    .thr   (thr)
  );

  ilhs_residue u_residue (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (counted),
    .divisor  (interval),
    .done     (mod_done),
    .rem      (mod_rem)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for insert_length_histogram_stats. A directed table of
// samples, finalizes, clears and no-ops is followed by random phases, one per
// update_interval setting. Every result is compared with a known table value or
// with a local histogram and quantile predictor. Random idling runs on both
// channels in some phases, plus two long receiver hold-offs.
// ----------------------------------------------------------------------------
module testbench;

  localparam int BINS   = ilhs_pkg::LENGTH_BINS_DEF;
  localparam int MODELS = ilhs_pkg::MODEL_COUNT_DEF;
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] CNT_SAT = 32'hFFFF_FFFF;
  localparam logic [ilhs_pkg::FRAC_W-1:0] QUANT_FRACS [ilhs_pkg::QUANT_N] = '{
    32'd5797768, 32'd681419127, 32'd2147483648, 32'd3613548169, 32'd4289169528
  };

  typedef struct packed {
    logic                             stable;
    logic                             updated;
    logic [ilhs_pkg::STAT_W-1:0]      min_length;
    logic [ilhs_pkg::STAT_W-1:0]      median_length;
    logic [ilhs_pkg::STAT_W-1:0]      max_length;
    logic [ilhs_pkg::STAT_W-1:0]      low_spread;
    logic [ilhs_pkg::STAT_W-1:0]      high_spread;
    logic [ilhs_pkg::MODEL_OUT_W-1:0] best_model;
    logic [ilhs_pkg::MODEL_OUT_W-1:0] second_model;
  } stats_t;

  typedef struct {
    ilhs_pkg::op_t                op;
    logic [ilhs_pkg::MODEL_W-1:0] model;
    logic [ilhs_pkg::LEN_W-1:0]   length;
    bit                           known;
    stats_t                       stats;
  } table_row_t;

  localparam stats_t STATS_EMPTY =
    '{1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd8, 4'd8};

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [ilhs_pkg::INTERVAL_W-1:0] cfg_wr_data;

  ilhs_item_if   item_ch();
  ilhs_result_if result_ch();

  insert_length_histogram_stats u_dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .item(item_ch), .result(result_ch)
  );

  // predictor state
  logic [31:0]                      hist_bins [MODELS][BINS];
  logic [31:0]                      model_sums [MODELS];
  logic [31:0]                      sample_count;
  logic [ilhs_pkg::STAT_W-1:0]      stat_vals [5];
  logic [ilhs_pkg::MODEL_OUT_W-1:0] pick_best, pick_second;
  logic                             stats_stable;
  logic [ilhs_pkg::INTERVAL_W-1:0]  interval_reg;

  stats_t pending_stats[$];
  int     error_count;
  bit     idling_on;
  bit     hold_request;

  function automatic void clear_histograms();
    foreach (hist_bins[m, i]) hist_bins[m][i] = '0;
    foreach (model_sums[m]) model_sums[m] = '0;
    sample_count = '0;
    foreach (stat_vals[k]) stat_vals[k] = 16'hFFFF;
    pick_best    = ilhs_pkg::INVALID_MODEL;
    pick_second  = ilhs_pkg::INVALID_MODEL;
    stats_stable = 1'b0;
  endfunction

  function automatic void recompute_quantiles();
    int b0, b1;
    logic [33:0] total, pos;
    logic [95:0] prod;
    logic [63:0] thr [ilhs_pkg::QUANT_N];
    int q [ilhs_pkg::QUANT_N];
    logic [ilhs_pkg::STAT_W-1:0] nv [5];
    bit same;
    b0 = (model_sums[1] <= model_sums[0]) ? 0 : 1;
    b1 = 1 - b0;
    for (int m = 2; m < MODELS; m++) begin
      if (model_sums[m] > model_sums[b0]) begin
        b1 = b0;
        b0 = m;
      end else if (model_sums[m] > model_sums[b1]) begin
        b1 = m;
      end
    end
    total = 34'(model_sums[b0]) + 34'(model_sums[b1]);
    for (int k = 0; k < ilhs_pkg::QUANT_N; k++) begin
      prod   = 96'(total) * 96'(QUANT_FRACS[k]);
      thr[k] = prod[95:32];
      q[k]   = 0;
    end
    pos = '0;
    for (int i = 0; i < BINS; i++) begin
      for (int k = 0; k < ilhs_pkg::QUANT_N; k++)
        if (64'(pos) <= thr[k]) q[k] = i;
      pos = pos + 34'(hist_bins[b0][i]) + 34'(hist_bins[b1][i]);
      if (pos > total) pos = total + 34'd1;
    end
    nv[0] = 16'(q[ilhs_pkg::Q_LO3]);
    nv[1] = 16'(q[ilhs_pkg::Q_MED]);
    nv[2] = 16'(q[ilhs_pkg::Q_HI3]);
    nv[3] = 16'(q[ilhs_pkg::Q_MED] - q[ilhs_pkg::Q_LO1]);
    nv[4] = 16'(q[ilhs_pkg::Q_HI1] - q[ilhs_pkg::Q_MED]);
    same = 1'b1;
    for (int k = 0; k < 5; k++) begin
      if (nv[k] != stat_vals[k]) same = 1'b0;
      stat_vals[k] = nv[k];
    end
    if (same) stats_stable = 1'b1;
    pick_best   = ilhs_pkg::MODEL_OUT_W'(b0);
    pick_second = ilhs_pkg::MODEL_OUT_W'(b1);
  endfunction

  function automatic stats_t predict_stats(ilhs_pkg::op_t op,
                                           logic [ilhs_pkg::MODEL_W-1:0] model,
                                           logic [ilhs_pkg::LEN_W-1:0] length);
    stats_t s;
    bit upd;
    upd = 1'b0;
    case (op)
      ilhs_pkg::OP_APPEND: begin
        if (length < BINS) begin
          if (hist_bins[model][length] != CNT_SAT)
            hist_bins[model][length] = hist_bins[model][length] + 32'd1;
          if (model_sums[model] != CNT_SAT) model_sums[model] = model_sums[model] + 32'd1;
          sample_count = sample_count + 32'd1;
          if (interval_reg != 0 && (sample_count % interval_reg) == 0) begin
            recompute_quantiles();
            upd = 1'b1;
          end
        end
      end
      ilhs_pkg::OP_FINAL: begin
        recompute_quantiles();
        upd = 1'b1;
      end
      ilhs_pkg::OP_CLEAR: clear_histograms();
      default: ;
    endcase
    s = '{stats_stable, upd, stat_vals[0], stat_vals[1], stat_vals[2], stat_vals[3],
          stat_vals[4], pick_best, pick_second};
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sender side: one transaction per call, valid stays up across gapless items
  task automatic send_item(ilhs_pkg::op_t op, logic [ilhs_pkg::MODEL_W-1:0] model,
                           logic [ilhs_pkg::LEN_W-1:0] length,
                           bit known, stats_t known_stats);
    int gap;
    stats_t s;
    gap = idling_on ? int'($urandom_range(0, 13)) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.operation <= op;
    item_ch.model     <= model;
    item_ch.length    <= length;
    do @(posedge clk); while (!item_ch.ready);
    s = predict_stats(op, model, length);
    pending_stats.push_back(known ? known_stats : s);
  endtask

  task automatic write_interval(logic [ilhs_pkg::INTERVAL_W-1:0] value);
    item_ch.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    interval_reg = value;
  endtask

  task automatic random_phase(int count, bit with_hold);
    int unsigned sel, pa, pb;
    ilhs_pkg::op_t op;
    logic [ilhs_pkg::MODEL_W-1:0] model;
    logic [ilhs_pkg::LEN_W-1:0] length;
    pa = $urandom_range(0, 7);
    pb = $urandom_range(0, 7);
    if (with_hold) hold_request = 1'b1;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 90)      op = ilhs_pkg::OP_APPEND;
      else if (sel < 96) op = ilhs_pkg::OP_FINAL;
      else if (sel < 97) op = ilhs_pkg::OP_CLEAR;
      else               op = ilhs_pkg::OP_NOP;
      sel = $urandom_range(0, 9);
      model = ilhs_pkg::MODEL_W'((sel < 4) ? pa : (sel < 7) ? pb : $urandom_range(0, 7));
      sel = $urandom_range(0, 99);
      if (sel < 80)
        length = ilhs_pkg::LEN_W'(200 + $urandom_range(0, 300) + $urandom_range(0, 300));
      else if (sel < 93)
        length = ilhs_pkg::LEN_W'($urandom_range(0, BINS - 1));
      else
        length = ilhs_pkg::LEN_W'($urandom_range(0, 65535));
      send_item(op, model, length, 1'b0, STATS_EMPTY);
    end
  endtask

  // receiver side
  initial begin
    int stall;
    result_ch.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = idling_on ? int'($urandom_range(0, 13)) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!(result_ch.valid && result_ch.ready));
    end
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    stats_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_stats.size() == 0) begin
        $error("result transaction with no expectation waiting");
        error_count++;
      end else begin
        e = pending_stats.pop_front();
        check_field("stable", e.stable, result_ch.stable);
        check_field("updated", e.updated, result_ch.updated);
        check_field("min_length", e.min_length, result_ch.min_length);
        check_field("median_length", e.median_length, result_ch.median_length);
        check_field("max_length", e.max_length, result_ch.max_length);
        check_field("low_spread", e.low_spread, result_ch.low_spread);
        check_field("high_spread", e.high_spread, result_ch.high_spread);
        check_field("best_model", e.best_model, result_ch.best_model);
        check_field("second_model", e.second_model, result_ch.second_model);
      end
    end
  end

  initial begin
    table_row_t rows [$];
    rows = '{
      '{ilhs_pkg::OP_NOP,    3'd0, 16'd0,     1'b1, STATS_EMPTY},
      '{ilhs_pkg::OP_FINAL,  3'd0, 16'd0,     1'b1,
        '{1'b0, 1'b1, 16'd2047, 16'd2047, 16'd2047, 16'd0, 16'd0, 4'd0, 4'd1}},
      // repeat of identical statistics latches stable
      '{ilhs_pkg::OP_FINAL,  3'd0, 16'd0,     1'b1,
        '{1'b1, 1'b1, 16'd2047, 16'd2047, 16'd2047, 16'd0, 16'd0, 4'd0, 4'd1}},
      '{ilhs_pkg::OP_CLEAR,  3'd0, 16'd0,     1'b1, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd0, 16'd0,     1'b1, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd7, 16'd2047,  1'b1, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd3, 16'd2048,  1'b1, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd5, 16'd65535, 1'b1, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd1, 16'd1000,  1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd2, 16'd1365,  1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd4, 16'd682,   1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd6, 16'd5,     1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd7, 16'd300,   1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd7, 16'd310,   1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_FINAL,  3'd0, 16'd0,     1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_NOP,    3'd7, 16'hFFFF,  1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_FINAL,  3'd0, 16'd0,     1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd2, 16'd100,   1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_APPEND, 3'd2, 16'd2000,  1'b0, STATS_EMPTY},
      '{ilhs_pkg::OP_FINAL,  3'd0, 16'd0,     1'b0, STATS_EMPTY}
    };
    error_count  = 0;
    idling_on    = 1'b1;
    hold_request = 1'b0;
    interval_reg = ilhs_pkg::INTERVAL_RESET;
    clear_histograms();
    rst = 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    item_ch.valid     <= 1'b0;
    item_ch.operation <= ilhs_pkg::OP_NOP;
    item_ch.model     <= '0;
    item_ch.length    <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[r])
      send_item(rows[r].op, rows[r].model, rows[r].length, rows[r].known, rows[r].stats);

    random_phase(300, 1'b0);
    write_interval(16'd1);
    idling_on = 1'b0;
    random_phase(30, 1'b0);
    write_interval(16'd0);
    idling_on = 1'b1;
    random_phase(150, 1'b1);
    write_interval(16'hFFFF);
    idling_on = 1'b0;
    random_phase(150, 1'b0);
    write_interval(16'd3);
    idling_on = 1'b1;
    random_phase(120, 1'b0);
    write_interval(16'd40);
    random_phase(400, 1'b1);
    write_interval(16'd250);
    random_phase(400, 1'b0);

    item_ch.valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
